@@ rtl/dkev_pkg.sv @@
package dkev_pkg;

	localparam int NUM_HARD_KEYS = 4;
	localparam int NUM_SOFT_KEYS = 6;

	localparam int HARD_ID_W   = 2;
	localparam int MAP_ENTRY_W = 5;
	localparam int MAP_W       = 30;
	localparam int CNT_W       = 8;
	localparam int SOFT_IDX_W  = 3;
	localparam int PADDR_W     = 5;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef logic [NUM_HARD_KEYS-1:0] hard_vec_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'd0,
		ST_BLOCK  = 3'd1,
		ST_PRESS  = 3'd2,
		ST_LONG   = 3'd3,
		ST_BROKEN = 3'd4
	} soft_state_t;

	typedef enum logic [1:0] {
		VIEW_UP    = 2'd0,
		VIEW_DOWN  = 2'd1,
		VIEW_BREAK = 2'd2
	} view_t;

	typedef enum logic [1:0] {
		EV_DOWN    = 2'd0,
		EV_LSTART  = 2'd1,
		EV_LHOLD   = 2'd2,
		EV_RELEASE = 2'd3
	} key_ev_t;

	typedef enum logic [2:0] {
		REG_IDLE_LEVELS = 3'd0,
		REG_FILTER      = 3'd1,
		REG_LONG_PRESS  = 3'd2,
		REG_HOLD        = 3'd3,
		REG_KEY_MAP     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic    vld;
		key_ev_t code;
	} soft_ev_t;

	function automatic cnt_t bump(input cnt_t c);
		return (c != CNT_MAX) ? c + cnt_t'(1) : c;
	endfunction

	function automatic hard_vec_t hard_pos(input logic [HARD_ID_W-1:0] id);
		hard_vec_t p;
		p = '0;
		if (32'(id) < NUM_HARD_KEYS)
			p[id] = 1'b1;
		return p;
	endfunction

endpackage

@@ rtl/dkev_hard_lane.sv @@
module dkev_hard_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                raw,
	input  logic                rest_level,
	input  dkev_pkg::cnt_t      filter_ticks,
	output logic                status
);
	import dkev_pkg::*;

	cnt_t cnt_q;
	logic status_q;
	cnt_t cnt_inc;
	logic pressed;

	assign pressed = raw ^ rest_level;
	assign cnt_inc = bump(cnt_q);
	assign status  = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			status_q <= 1'b0;
		end else if (tick) begin
			if (pressed != status_q) begin
				if (cnt_inc >= filter_ticks) begin
					cnt_q    <= '0;
					status_q <= ~status_q;
				end else begin
					cnt_q <= cnt_inc;
				end
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

@@ rtl/dkev_soft_lane.sv @@
module dkev_soft_lane (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  dkev_pkg::hard_vec_t                 status,
	input  logic [dkev_pkg::MAP_ENTRY_W-1:0]    map_entry,
	input  dkev_pkg::cnt_t                      long_press_ticks,
	input  dkev_pkg::cnt_t                      hold_ticks,
	output dkev_pkg::soft_ev_t                  ev
);
	import dkev_pkg::*;

	soft_state_t state_q, state_d;
	cnt_t        hold_q, hold_d;
	cnt_t        hold_inc, lim;
	view_t       view;
	hard_vec_t   pos_p, pos_s;
	logic        composite;

	assign composite = map_entry[4];
	assign pos_p     = hard_pos(map_entry[1:0]);
	assign pos_s     = hard_pos(map_entry[3:2]);
	assign hold_inc  = bump(hold_q);
	assign lim       = (state_q == ST_PRESS) ? long_press_ticks : hold_ticks;

	always_comb begin
		if (!composite) begin
			if ((status & ~pos_p) != '0)
				view = VIEW_BREAK;
			else if ((status & pos_p) != '0)
				view = VIEW_DOWN;
			else
				view = VIEW_UP;
		end else begin
			if ((status & ~(pos_p | pos_s)) != '0)
				view = VIEW_BREAK;
			else if ((status & pos_p) != '0)
				view = ((status & pos_s) != '0) ? VIEW_DOWN : VIEW_UP;
			else if ((status & pos_s) != '0)
				view = VIEW_BREAK;
			else
				view = VIEW_UP;
		end
	end

	always_comb begin
		state_d = state_q;
		hold_d  = hold_q;
		ev.vld  = 1'b0;
		ev.code = EV_DOWN;
		case (state_q)
			ST_IDLE: begin
				if (view == VIEW_BREAK) begin
					state_d = ST_BLOCK;
				end else if (view == VIEW_DOWN) begin
					ev.vld  = 1'b1;
					ev.code = EV_DOWN;
					hold_d  = '0;
					state_d = ST_PRESS;
				end
			end
			ST_BLOCK: begin
				if (view == VIEW_UP)
					state_d = ST_IDLE;
			end
			ST_PRESS, ST_LONG: begin
				if (view == VIEW_BREAK) begin
					state_d = ST_BROKEN;
				end else if (view == VIEW_DOWN) begin
					hold_d = hold_inc;
					if (hold_inc >= lim) begin
						ev.vld  = 1'b1;
						ev.code = (state_q == ST_PRESS) ? EV_LSTART : EV_LHOLD;
						hold_d  = '0;
						state_d = ST_LONG;
					end
				end else begin
					ev.vld  = 1'b1;
					ev.code = EV_RELEASE;
					state_d = ST_IDLE;
				end
			end
			ST_BROKEN: begin
				if (view == VIEW_UP) begin
					ev.vld  = 1'b1;
					ev.code = EV_RELEASE;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hold_q  <= '0;
		end else if (step) begin
			state_q <= state_d;
			hold_q  <= hold_d;
		end
	end

endmodule

@@ rtl/dkev_merge.sv @@
module dkev_merge (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            load,
	input  dkev_pkg::soft_ev_t [dkev_pkg::NUM_SOFT_KEYS-1:0] evs,
	output logic                                            free,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output logic [dkev_pkg::SOFT_IDX_W-1:0]                 soft_key,
	output logic [1:0]                                      key_event,
	output logic                                            last_of_tick
);
	import dkev_pkg::*;

	logic [NUM_SOFT_KEYS-1:0] mask_q;
	key_ev_t                  code_q [NUM_SOFT_KEYS];
	logic [NUM_SOFT_KEYS-1:0] mask_rest;
	logic [SOFT_IDX_W-1:0]    idx;

	// lowest pending lane first
	always_comb begin
		idx = '0;
		for (int k = NUM_SOFT_KEYS - 1; k >= 0; k--) begin
			if (mask_q[k])
				idx = SOFT_IDX_W'(k);
		end
	end

	assign mask_rest    = mask_q & (mask_q - NUM_SOFT_KEYS'(1));
	assign out_valid    = mask_q != '0;
	assign last_of_tick = mask_rest == '0;
	assign soft_key     = idx;
	assign key_event    = code_q[idx];
	assign free         = !out_valid || (out_ready && last_of_tick);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			for (int k = 0; k < NUM_SOFT_KEYS; k++)
				mask_q[k] <= evs[k].vld;
		end else if (out_valid && out_ready) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < NUM_SOFT_KEYS; k++)
				code_q[k] <= evs[k].code;
		end
	end

endmodule

@@ rtl/debounced_key_event_fsm.sv @@
// Key event engine: each accepted tick carries the raw levels of the hard keys. The tick is
// debounced in the cycle it is accepted and registered in stage 1; the soft key machines all
// step together once the merge stage is free, and the events they raise (at most one per
// soft key) then leave one beat per cycle while out_ready is set, in soft key order, the last
// beat of a tick flagged by last_of_tick. A new tick is taken every cycle while ticks raise
// at most one event and out_ready is set; more events hold the next tick in stage 1 until
// the last beat is taken. Configure through the APB port only while no tick is in flight.
module debounced_key_event_fsm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dkev_pkg::PADDR_W-1:0]        paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [dkev_pkg::NUM_HARD_KEYS-1:0]  raw_levels,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dkev_pkg::SOFT_IDX_W-1:0]     soft_key,
	output logic [1:0]                          key_event,
	output logic                                last_of_tick
);
	import dkev_pkg::*;

	hard_vec_t              rest_levels_q;
	cnt_t                   filter_ticks_q;
	cnt_t                   long_press_q;
	cnt_t                   hold_ticks_q;
	logic [MAP_W-1:0]       key_map_q;
	logic                   tick_s1;
	logic                   tick;
	logic                   free;
	logic                   step;
	logic                   wr;
	reg_idx_t               reg_sel;
	hard_vec_t              status;
	soft_ev_t [NUM_SOFT_KEYS-1:0] evs;

	assign pready  = 1'b1;
	assign wr      = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rest_levels_q  <= hard_vec_t'(7);
			filter_ticks_q <= cnt_t'(2);
			long_press_q   <= cnt_t'(100);
			hold_ticks_q   <= cnt_t'(5);
			key_map_q      <= MAP_W'(925992992);
		end else if (wr) begin
			case (reg_sel)
				REG_IDLE_LEVELS: rest_levels_q  <= pwdata[NUM_HARD_KEYS-1:0];
				REG_FILTER:      filter_ticks_q <= pwdata[CNT_W-1:0];
				REG_LONG_PRESS:  long_press_q   <= pwdata[CNT_W-1:0];
				REG_HOLD:        hold_ticks_q   <= pwdata[CNT_W-1:0];
				REG_KEY_MAP:     key_map_q      <= pwdata[MAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IDLE_LEVELS: prdata = 32'(rest_levels_q);
			REG_FILTER:      prdata = 32'(filter_ticks_q);
			REG_LONG_PRESS:  prdata = 32'(long_press_q);
			REG_HOLD:        prdata = 32'(hold_ticks_q);
			REG_KEY_MAP:     prdata = 32'(key_map_q);
			default:         prdata = '0;
		endcase
	end

	// debounced status only moves on a new tick, so it still matches the tick in stage 1
	assign step     = tick_s1 && free;
	assign in_ready = !tick_s1 || free;
	assign tick     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tick_s1 <= 1'b0;
		else if (in_ready)
			tick_s1 <= in_valid;
	end

	for (genvar i = 0; i < NUM_HARD_KEYS; i++) begin : g_hard
		dkev_hard_lane u_hard (
			.clk          (clk),
			.arst_n       (arst_n),
			.tick         (tick),
			.raw          (raw_levels[i]),
			.rest_level   (rest_levels_q[i]),
			.filter_ticks (filter_ticks_q),
			.status       (status[i])
		);
	end

	for (genvar k = 0; k < NUM_SOFT_KEYS; k++) begin : g_soft
		dkev_soft_lane u_soft (
			.clk              (clk),
			.arst_n           (arst_n),
			.step             (step),
			.status           (status),
			.map_entry        (key_map_q[k*MAP_ENTRY_W +: MAP_ENTRY_W]),
			.long_press_ticks (long_press_q),
			.hold_ticks       (hold_ticks_q),
			.ev               (evs[k])
		);
	end

	dkev_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.evs          (evs),
		.free         (free),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.soft_key     (soft_key),
		.key_event    (key_event),
		.last_of_tick (last_of_tick)
	);

endmodule
